// ===== sv/gbkp_pkg.sv =====
package gbkp_pkg;

  // Fixed-point format and word geometry.
  localparam int FRAC_BITS       = 16;
  localparam int MAX_PARITY_BITS = 32;
  localparam int WORD_BITS       = 32;
  localparam int WORD_LSB        = $clog2(WORD_BITS);

  // Field widths.
  localparam int SAMPLE_W = 32;
  localparam int SPREAD_W = 31;
  localparam int SHIFT_W  = 5;
  localparam int PARITY_W = 6;
  localparam int KEYLEN_W = 13;

  // Guard band width after the product is scaled back to Q16.16.
  localparam int PROD_W = 2 * SPREAD_W;
  localparam int BAND_W = PROD_W - FRAC_BITS;
  localparam int DEV_W  = SAMPLE_W + 1;
  localparam int CMP_W  = (BAND_W > DEV_W) ? BAND_W : DEV_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD_FACTOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_SHIFT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PARITY_BITS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BITS     = 3'd5;

  // Register reset values.
  localparam logic [SAMPLE_W-1:0] AVERAGE_RST      = 32'd0;
  localparam logic [SPREAD_W-1:0] SPREAD_RST       = 31'd65536;
  localparam logic [SPREAD_W-1:0] GUARD_FACTOR_RST = 31'd65536;
  localparam logic [SHIFT_W-1:0]  SCALE_SHIFT_RST  = 5'd1;
  localparam logic [PARITY_W-1:0] PARITY_BITS_RST  = 6'd8;
  localparam logic [KEYLEN_W-1:0] KEY_BITS_RST     = 13'd256;

endpackage

// ===== sv/gbkp_sample_if.sv =====
interface gbkp_sample_if;
  import gbkp_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ===== sv/gbkp_key_if.sv =====
interface gbkp_key_if;
  import gbkp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] key_word;
  logic                 last_word;

  modport source (output valid, output key_word, output last_word, input ready);
  modport sink (input valid, input key_word, input last_word, output ready);
endinterface

// ===== sv/gbkp_cfg_if.sv =====
interface gbkp_cfg_if;
  import gbkp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/guard_band_key_bit_packer.sv =====
// Guard band key bit packer.
//
// Channels: samples carries one signed Q16.16 sample per word; keys carries
// one 32-bit key word per word, earliest key bit in bit 0, with last_word set
// on the word that completes a key; cfg writes one of six registers by index
// (average, spread, guard_factor, scale_shift, parity_bits, key_bits) and is
// ready whenever rst is low. Write cfg only while no sample is in flight.
//
// An accepted sample is held in the input register; from there it updates
// the key state and, if it completes a word, loads the output register.
// Throughput: one sample per cycle unless keys stalls; the input register
// feeds the combinational deviation, guard band compare and parity logic.
// Samples that fall outside the guard band, or that do not complete a word,
// give no output. The guard band product is registered from the configuration.
//
// Reset (rst, synchronous) restores the register defaults, clears the partial
// word and the bit count, and empties both pipeline registers. When keys
// stalls, the finished word waits in the output register while samples keep
// flowing until a sample would complete the next word; that sample then waits
// in the input register and samples.ready drops.
module guard_band_key_bit_packer (
  input  logic          clk,
  input  logic          rst,
  gbkp_sample_if.sink   samples,
  gbkp_key_if.source    keys,
  gbkp_cfg_if.sink      cfg
);
  import gbkp_pkg::*;

  // Configuration registers.
  logic [SAMPLE_W-1:0] average;
  logic [SPREAD_W-1:0] spread;
  logic [SPREAD_W-1:0] guard_factor;
  logic [SHIFT_W-1:0]  scale_shift;
  logic [PARITY_W-1:0] parity_bits;
  logic [KEYLEN_W-1:0] key_bits;

  // Registered guard band.
  logic [PROD_W-1:0] band_prod;
  logic [BAND_W-1:0] band;

  // Key state.
  logic [WORD_BITS-1:0] bit_shifter;
  logic [KEYLEN_W-1:0]  bits_in_key;

  // Input register.
  logic                s_valid;
  logic [SAMPLE_W-1:0] s_sample;

  // Output register.
  logic                 o_valid;
  logic [WORD_BITS-1:0] o_word;
  logic                 o_last;

  // Datapath signals.
  logic signed [DEV_W-1:0] dev;
  logic [DEV_W-1:0]        mag;
  logic                    pass;
  logic [SHIFT_W-1:0]      sh;
  logic [63:0]             scaled;
  logic [WORD_BITS-1:0]    low_bits;
  logic [PARITY_W-1:0]     h;
  logic [WORD_BITS-1:0]    mask;
  logic                    key_bit;
  logic [KEYLEN_W-1:0]     cnt_inc;
  logic [KEYLEN_W-1:0]     key_len;
  logic                    word_full;
  logic                    key_done;
  logic                    produce;
  logic                    out_free;
  logic                    advance;
  logic [WORD_BITS-1:0]    bit_shifter_next;

  assign cfg.ready = !rst;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      average      <= AVERAGE_RST;
      spread       <= SPREAD_RST;
      guard_factor <= GUARD_FACTOR_RST;
      scale_shift  <= SCALE_SHIFT_RST;
      parity_bits  <= PARITY_BITS_RST;
      key_bits     <= KEY_BITS_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_AVERAGE:      average      <= cfg.data[SAMPLE_W-1:0];
        REG_SPREAD:       spread       <= cfg.data[SPREAD_W-1:0];
        REG_GUARD_FACTOR: guard_factor <= cfg.data[SPREAD_W-1:0];
        REG_SCALE_SHIFT:  scale_shift  <= cfg.data[SHIFT_W-1:0];
        REG_PARITY_BITS:  parity_bits  <= cfg.data[PARITY_W-1:0];
        REG_KEY_BITS:     key_bits     <= cfg.data[KEYLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // The guard band is registered and follows the registers in the cycle after.
  assign band_prod = PROD_W'(spread) * PROD_W'(guard_factor);

  always_ff @(posedge clk) begin
    if (rst) begin
      band <= BAND_W'((PROD_W'(SPREAD_RST) * PROD_W'(GUARD_FACTOR_RST)) >> FRAC_BITS);
    end else begin
      band <= band_prod[PROD_W-1:FRAC_BITS];
    end
  end

  // Deviation and guard band check.
  assign dev  = $signed({s_sample[SAMPLE_W-1], s_sample})
              - $signed({average[SAMPLE_W-1], average});
  assign mag  = dev[DEV_W-1] ? DEV_W'(-dev) : DEV_W'(dev);
  assign pass = CMP_W'(mag) < CMP_W'(band);

  // Scale, floor and take the parity of the low quantized bits.
  assign sh       = (scale_shift == '0) ? '0 : scale_shift - SHIFT_W'(1);
  assign scaled   = {{(64 - DEV_W){dev[DEV_W-1]}}, dev} << sh;
  assign low_bits = scaled[FRAC_BITS +: WORD_BITS];
  assign h        = (parity_bits > PARITY_W'(MAX_PARITY_BITS))
                  ? PARITY_W'(MAX_PARITY_BITS) : parity_bits;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      mask[j] = (PARITY_W'(j) < h);
    end
  end

  assign key_bit = ^(low_bits & mask);

  // Word and key boundaries.
  assign cnt_inc   = bits_in_key + KEYLEN_W'(1);
  assign word_full = (cnt_inc[WORD_LSB-1:0] == '0);
  assign key_len   = (key_bits[KEYLEN_W-1:WORD_LSB] == '0)
                   ? KEYLEN_W'(WORD_BITS)
                   : {key_bits[KEYLEN_W-1:WORD_LSB], {WORD_LSB{1'b0}}};
  assign key_done  = (cnt_inc >= key_len);
  assign bit_shifter_next = {key_bit, bit_shifter[WORD_BITS-1:1]};

  // Handshake: a sample leaves the input register unless it would complete
  // a word while the output register is still occupied.
  assign produce       = s_valid && pass && word_full;
  assign out_free      = !o_valid || keys.ready;
  assign advance       = s_valid && (!produce || out_free);
  assign samples.ready = !rst && (!s_valid || advance);

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (samples.ready) begin
      s_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s_sample <= samples.sample;
    end
  end

  // Key state update for every sample inside the guard band.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_shifter <= '0;
      bits_in_key <= '0;
    end else if (advance && pass) begin
      bit_shifter <= bit_shifter_next;
      bits_in_key <= (word_full && key_done) ? '0 : cnt_inc;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance && produce) begin
      o_valid <= 1'b1;
    end else if (keys.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      o_word <= bit_shifter_next;
      o_last <= key_done;
    end
  end

  assign keys.valid     = o_valid;
  assign keys.key_word  = o_word;
  assign keys.last_word = o_last;

  // A word that is produced appears on the output channel.
  a_word_shown: assert property (@(posedge clk) disable iff (rst)
    advance && produce |=> keys.valid)
    else $error("produced key word not presented");

  // Completing a key restarts the bit count.
  a_key_restart: assert property (@(posedge clk) disable iff (rst)
    advance && produce && key_done |=> bits_in_key == '0)
    else $error("bit count not cleared at end of key");

  // With the output register empty, the input side never stalls.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !keys.valid |-> samples.ready)
    else $error("input stalled with empty output register");

  // A sample outside the guard band never holds up the input register.
  a_drop_moves: assert property (@(posedge clk) disable iff (rst)
    s_valid && !pass |-> advance)
    else $error("dropped sample stalled the pipeline");

  // The bit count only moves when a sample inside the band advances.
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !(advance && pass) |=> bits_in_key == $past(bits_in_key))
    else $error("bit count changed without an accepted key bit");

endmodule
